>>> hdl/dmd_pkg.sv
// Package for the device message deframer: beat structs, codes and size constants.
// No dependencies; imported by device_message_deframer.
package dmd_pkg;

   localparam int MAX_PAYLOAD = 32;
   localparam int STORE_DEPTH = 32;
   localparam int IDX_W       = $clog2(STORE_DEPTH);

   localparam logic [15:0] SYNC_PAUSE_RESET = 16'd100;
   localparam logic [7:0]  TYPE_MASK        = 8'hC7;
   localparam logic [7:0]  INFO_TYPE_MASK   = 8'hC0;
   localparam logic [7:0]  CHECK_GOOD       = 8'hFF;

   // header kinds (top two bits)
   localparam logic [1:0] KIND_SYSTEM  = 2'd0;
   localparam logic [1:0] KIND_COMMAND = 2'd1;
   localparam logic [1:0] KIND_INFO    = 2'd2;

   // system message codes (low three bits)
   localparam logic [2:0] SYS_ACK = 3'd4;
   localparam logic [2:0] SYS_PRG = 3'd5;

   // input beat kinds
   localparam logic [1:0] REQ_BYTE      = 2'd0;
   localparam logic [1:0] REQ_FRAME_ERR = 2'd1;
   localparam logic [1:0] REQ_TICK      = 2'd2;
   localparam logic [1:0] REQ_RESTART   = 2'd3;

   // result status codes
   localparam logic [1:0] STATUS_GOOD     = 2'd0;
   localparam logic [1:0] STATUS_CSUM_ERR = 2'd1;
   localparam logic [1:0] STATUS_OVERLONG = 2'd2;

   typedef enum logic [1:0] {
      PH_NOSYNC,
      PH_HEADER,
      PH_CMD,
      PH_PAYLOAD
   } parse_phase_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_EXEC,
      SEQ_CSUM,
      SEQ_ONE,
      SEQ_READ,
      SEQ_EMIT
   } seq_state_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [7:0]       msg_type;
      logic [3:0]       msg_mode;
      logic [7:0]       msg_cmd;
      logic [7:0]       payload_len;
      logic [IDX_W-1:0] byte_index;
      logic [7:0]       payload_byte;
      logic             last;
      logic [15:0]      framing_errors;
      logic [15:0]      checksum_errors;
   } rsp_payload_type;

endpackage

>>> hdl/device_message_deframer.sv
// Device message deframer top level: header/command/payload parser, payload store,
// one shared saturating incrementer under a small sequencer. Depends on dmd_pkg.
//
// Each input beat is accepted in idle, then executed. A beat that ends a message loads
// its first result into the output register from the one-result state (ACK, overlong),
// after a count step (checksum error) or after a store read (good message). A good message
// drains as store read, then load, for each result, bound by the single store read port.
// No input beat is taken until the last one is executed and its results are loaded.
// Reset: synchronous, active high; clears parser state, counters and output valid and
// loads sync_pause_ticks with 100. The payload store is not cleared.
module device_message_deframer
   import dmd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_wr_en,
   input  logic [15:0]     csr_wr_data
);

   // sequencer and parser state
   seq_state_type   seq_ff, seq_in;
   parse_phase_type phase_ff, phase_in;
   logic [7:0]      pos_ff, pos_in;
   logic [7:0]      type_ff, type_in;
   logic [3:0]      mode_ff, mode_in;
   logic [7:0]      cmd_ff, cmd_in;
   logic [7:0]      len_ff, len_in;
   logic [7:0]      chk_ff, chk_in;
   logic [15:0]     idle_ff, idle_in;
   logic [15:0]     frm_cnt_ff, frm_cnt_in;
   logic [15:0]     csum_cnt_ff, csum_cnt_in;
   logic [15:0]     pause_ff, pause_in;

   // payload registers (no reset)
   req_payload_type req_hold_ff;
   logic [1:0]      status_ff, status_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]      rd_data_ff;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   // payload store
   logic [7:0]      store_mem [STORE_DEPTH];
   logic            mem_we;

   // shared saturating incrementer
   logic [15:0]     inc_op;
   logic [15:0]     inc_res;

   // decode of the held beat
   logic       req_accept;
   logic       is_byte;
   logic [7:0] rx_b;
   logic [1:0] kind;
   logic [2:0] f1;
   logic [2:0] f2;
   logic [7:0] hdr_len;
   logic [7:0] chk_x;
   logic       do_header;
   logic       exec_ack;
   logic       exec_complete;
   logic       chk_bad;
   logic       too_long;
   logic       slot_free;
   logic       rsp_load;

   assign req_accept = req_valid && req_ready;
   assign is_byte    = (req_hold_ff.req_type == REQ_BYTE);
   assign rx_b       = req_hold_ff.rx_byte;
   assign kind       = rx_b[7:6];
   assign f1         = rx_b[5:3];
   assign f2         = rx_b[2:0];
   assign hdr_len    = 8'd1 << f1;
   assign chk_x      = chk_ff ^ rx_b;
   // a byte is a header in the header phase, or in nosync once the line was quiet long enough
   assign do_header  = is_byte && ((phase_ff == PH_HEADER) ||
                       ((phase_ff == PH_NOSYNC) && (idle_ff >= pause_ff)));
   assign exec_ack   = do_header && (kind == KIND_SYSTEM) && (f2 == SYS_ACK);
   // checksum byte: arrives once all declared payload bytes are in
   assign exec_complete = is_byte && (phase_ff == PH_PAYLOAD) && !(pos_ff < len_ff);
   assign chk_bad    = (chk_x != CHECK_GOOD);
   assign too_long   = (len_ff > 8'(MAX_PAYLOAD));
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   // operand select for the shared unit; exec picks its count by beat kind, CSUM and EMIT own one each
   always_comb begin
      inc_op = '0;
      unique case (seq_ff)
         SEQ_EXEC: begin
            case (req_hold_ff.req_type)
               REQ_TICK:      inc_op = idle_ff;
               REQ_FRAME_ERR: inc_op = frm_cnt_ff;
               default:       inc_op = {8'd0, pos_ff};
            endcase
         end
         SEQ_CSUM: inc_op = csum_cnt_ff;
         SEQ_EMIT: inc_op = {{(16-IDX_W){1'b0}}, idx_ff};
         default:  inc_op = '0;
      endcase
   end

   assign inc_res = (inc_op == 16'hFFFF) ? inc_op : inc_op + 16'd1;

   // sequencer next state
   always_comb begin
      seq_in = seq_ff;
      unique case (seq_ff)
         SEQ_IDLE: begin
            if (req_valid) seq_in = SEQ_EXEC;
         end
         SEQ_EXEC: begin
            if (exec_ack) begin
               seq_in = SEQ_ONE;
            end else if (exec_complete) begin
               if (chk_bad)       seq_in = SEQ_CSUM;
               else if (too_long) seq_in = SEQ_ONE;
               else               seq_in = SEQ_READ;
            end else begin
               seq_in = SEQ_IDLE;
            end
         end
         SEQ_CSUM: seq_in = SEQ_ONE;
         SEQ_ONE: begin
            if (slot_free) seq_in = SEQ_IDLE;
         end
         SEQ_READ: seq_in = SEQ_EMIT;
         SEQ_EMIT: begin
            if (slot_free) begin
               seq_in = (inc_res[7:0] == len_ff) ? SEQ_IDLE : SEQ_READ;
            end
         end
         default: seq_in = SEQ_IDLE;
      endcase
   end

   // sequencer outputs and datapath next values
   always_comb begin
      req_ready      = (seq_ff == SEQ_IDLE);
      phase_in       = phase_ff;
      pos_in         = pos_ff;
      type_in        = type_ff;
      mode_in        = mode_ff;
      cmd_in         = cmd_ff;
      len_in         = len_ff;
      chk_in         = chk_ff;
      idle_in        = idle_ff;
      frm_cnt_in     = frm_cnt_ff;
      csum_cnt_in    = csum_cnt_ff;
      status_in      = status_ff;
      idx_in         = idx_ff;
      mem_we         = 1'b0;
      rsp_load       = 1'b0;
      rsp_payload_in = rsp_payload_ff;
      pause_in       = csr_wr_en ? csr_wr_data : pause_ff;

      unique case (seq_ff)
         SEQ_EXEC: begin
            case (req_hold_ff.req_type)
               REQ_FRAME_ERR: begin
                  frm_cnt_in = inc_res;
                  phase_in   = PH_HEADER;
               end
               REQ_TICK: idle_in = inc_res;
               REQ_RESTART: begin
                  phase_in    = PH_NOSYNC;
                  idle_in     = '0;
                  frm_cnt_in  = '0;
                  csum_cnt_in = '0;
               end
               default: begin
                  idle_in = '0;
                  chk_in  = chk_x;
                  if (do_header) begin
                     chk_in   = rx_b;
                     type_in  = rx_b & TYPE_MASK;
                     cmd_in   = '0;
                     mode_in  = '0;
                     len_in   = '0;
                     pos_in   = '0;
                     phase_in = PH_HEADER;
                     case (kind)
                        KIND_SYSTEM: begin
                           if (f2 == SYS_ACK) begin
                              chk_in    = CHECK_GOOD;
                              status_in = STATUS_GOOD;
                           end else if (f2 == SYS_PRG) begin
                              len_in   = hdr_len;
                              phase_in = PH_CMD;
                           end
                        end
                        KIND_COMMAND: begin
                           len_in   = hdr_len;
                           phase_in = PH_PAYLOAD;
                        end
                        default: begin
                           mode_in  = {1'b0, f2};
                           type_in  = rx_b & INFO_TYPE_MASK;
                           len_in   = hdr_len;
                           phase_in = (kind == KIND_INFO) ? PH_CMD : PH_PAYLOAD;
                        end
                     endcase
                  end else if (phase_ff == PH_CMD) begin
                     cmd_in   = rx_b;
                     mode_in  = mode_ff | {rx_b[5], 3'b000};
                     phase_in = PH_PAYLOAD;
                  end else if (phase_ff == PH_PAYLOAD) begin
                     if (pos_ff < len_ff) begin
                        mem_we = (pos_ff < 8'(MAX_PAYLOAD));
                        pos_in = inc_res[7:0];
                     end else begin
                        phase_in = PH_HEADER;
                        idx_in   = '0;
                        if (chk_bad)       status_in = STATUS_CSUM_ERR;
                        else if (too_long) status_in = STATUS_OVERLONG;
                        else               status_in = STATUS_GOOD;
                     end
                  end
               end
            endcase
         end
         SEQ_CSUM: csum_cnt_in = inc_res;
         SEQ_ONE: begin
            // single-beat result: ACK, checksum error or overlong
            rsp_load                       = slot_free;
            rsp_payload_in.status          = status_ff;
            rsp_payload_in.msg_type        = type_ff;
            rsp_payload_in.msg_mode        = mode_ff;
            rsp_payload_in.msg_cmd         = cmd_ff;
            rsp_payload_in.payload_len     = len_ff;
            rsp_payload_in.byte_index      = '0;
            rsp_payload_in.payload_byte    = '0;
            rsp_payload_in.last            = 1'b1;
            rsp_payload_in.framing_errors  = frm_cnt_ff;
            rsp_payload_in.checksum_errors = csum_cnt_ff;
         end
         SEQ_EMIT: begin
            rsp_load                       = slot_free;
            rsp_payload_in.status          = STATUS_GOOD;
            rsp_payload_in.msg_type        = type_ff;
            rsp_payload_in.msg_mode        = mode_ff;
            rsp_payload_in.msg_cmd         = cmd_ff;
            rsp_payload_in.payload_len     = len_ff;
            rsp_payload_in.byte_index      = idx_ff;
            rsp_payload_in.payload_byte    = rd_data_ff;
            rsp_payload_in.last            = (inc_res[7:0] == len_ff);
            rsp_payload_in.framing_errors  = frm_cnt_ff;
            rsp_payload_in.checksum_errors = csum_cnt_ff;
            if (slot_free) idx_in = inc_res[IDX_W-1:0];
         end
         default: begin
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_IDLE;
         phase_ff     <= PH_NOSYNC;
         pos_ff       <= '0;
         type_ff      <= '0;
         mode_ff      <= '0;
         cmd_ff       <= '0;
         len_ff       <= '0;
         chk_ff       <= '0;
         idle_ff      <= '0;
         frm_cnt_ff   <= '0;
         csum_cnt_ff  <= '0;
         pause_ff     <= SYNC_PAUSE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         type_ff      <= type_in;
         mode_ff      <= mode_in;
         cmd_ff       <= cmd_in;
         len_ff       <= len_in;
         chk_ff       <= chk_in;
         idle_ff      <= idle_in;
         frm_cnt_ff   <= frm_cnt_in;
         csum_cnt_ff  <= csum_cnt_in;
         pause_ff     <= pause_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) req_hold_ff <= req_payload;
      if (rsp_load)   rsp_payload_ff <= rsp_payload_in;
      status_ff <= status_in;
      idx_ff    <= idx_in;
   end

   // payload store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) store_mem[pos_ff[IDX_W-1:0]] <= rx_b;
      rd_data_ff <= store_mem[idx_ff];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while beat pending");

   // a good message drains only with a length the store can hold
   a_drain_len: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SEQ_EMIT) |-> (len_ff != 8'd0 && len_ff <= 8'(MAX_PAYLOAD)))
      else $error("drain with bad payload length");

   // checksum count moves only in the count step or on restart
   a_csum_cnt: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && csum_cnt_ff != $past(csum_cnt_ff))
         |-> ($past(seq_ff) == SEQ_CSUM || $past(seq_ff) == SEQ_EXEC))
      else $error("checksum count changed outside its step");

endmodule

>>> dv/dmd_tb_pkg.sv
// Scoreboard for the device message deframer bench. It predicts the parser and
// holds the queue of results still due from it. Depends on dmd_pkg.
package dmd_tb_pkg;
   import dmd_pkg::*;

   class message_scoreboard;
      parse_phase_type phase;
      logic [15:0]     pause_ticks;
      logic [15:0]     idle_ticks;
      logic [15:0]     framing_count;
      logic [15:0]     checksum_count;
      logic [7:0]      payload_pos;
      logic [7:0]      hdr_type;
      logic [3:0]      hdr_mode;
      logic [7:0]      hdr_cmd;
      logic [7:0]      declared_len;
      logic [7:0]      running_check;
      logic [7:0]      payload_store [STORE_DEPTH];
      rsp_payload_type due_results [$];
      int              fail_count;

      function new();
         pause_ticks    = SYNC_PAUSE_RESET;
         phase          = PH_NOSYNC;
         idle_ticks     = '0;
         framing_count  = '0;
         checksum_count = '0;
         payload_pos    = '0;
         hdr_type       = '0;
         hdr_mode       = '0;
         hdr_cmd        = '0;
         declared_len   = '0;
         running_check  = '0;
         foreach (payload_store[i]) payload_store[i] = '0;
         fail_count     = 0;
      endfunction

      function void set_pause(input logic [15:0] ticks);
         pause_ticks = ticks;
      endfunction

      function string describe(input rsp_payload_type r);
         return $sformatf({"status=%0d type=%h mode=%h cmd=%h len=%0d idx=%0d byte=%h",
                           " last=%b fe=%0d ce=%0d"},
                          r.status, r.msg_type, r.msg_mode, r.msg_cmd, r.payload_len,
                          r.byte_index, r.payload_byte, r.last, r.framing_errors,
                          r.checksum_errors);
      endfunction

      function void flag(input string msg);
         fail_count++;
         if (fail_count <= 10) $display("%0t: %s", $time, msg);
      endfunction

      function void expect_result(input logic [1:0] status, input logic [IDX_W-1:0] idx,
                                  input logic [7:0] data, input logic last);
         rsp_payload_type r;
         r.status          = status;
         r.msg_type        = hdr_type;
         r.msg_mode        = hdr_mode;
         r.msg_cmd         = hdr_cmd;
         r.payload_len     = declared_len;
         r.byte_index      = idx;
         r.payload_byte    = data;
         r.last            = last;
         r.framing_errors  = framing_count;
         r.checksum_errors = checksum_count;
         due_results.push_back(r);
      endfunction

      // checksum byte seen (or ACK): decide the verdict and queue its beats
      function void close_message();
         int i;
         phase = PH_HEADER;
         if (running_check != CHECK_GOOD) begin
            if (checksum_count != 16'hFFFF) checksum_count++;
            expect_result(STATUS_CSUM_ERR, '0, '0, 1'b1);
         end else if (declared_len > MAX_PAYLOAD) begin
            expect_result(STATUS_OVERLONG, '0, '0, 1'b1);
         end else if (declared_len == 0) begin
            expect_result(STATUS_GOOD, '0, '0, 1'b1);
         end else begin
            for (i = 0; i < declared_len; i++)
               expect_result(STATUS_GOOD, IDX_W'(i), payload_store[i], i + 1 == declared_len);
         end
      endfunction

      function void take_header(input logic [7:0] b);
         logic [1:0] kind;
         logic [2:0] size_code;
         logic [2:0] low;
         kind          = b[7:6];
         size_code     = b[5:3];
         low           = b[2:0];
         running_check = b;
         hdr_type      = b & TYPE_MASK;
         hdr_cmd       = '0;
         hdr_mode      = '0;
         declared_len  = '0;
         payload_pos   = '0;
         phase         = PH_HEADER;
         case (kind)
            KIND_SYSTEM: begin
               if (low == SYS_ACK) begin
                  running_check = CHECK_GOOD;
                  close_message();
               end else if (low == SYS_PRG) begin
                  declared_len = 8'd1 << size_code;
                  phase        = PH_CMD;
               end
            end
            KIND_COMMAND: begin
               declared_len = 8'd1 << size_code;
               phase        = PH_PAYLOAD;
            end
            default: begin
               hdr_mode     = {1'b0, low};
               hdr_type     = hdr_type & INFO_TYPE_MASK;
               declared_len = 8'd1 << size_code;
               phase        = (kind == KIND_INFO) ? PH_CMD : PH_PAYLOAD;
            end
         endcase
      endfunction

      function void deframe_beat(input req_payload_type beat);
         logic [7:0] b;
         b = beat.rx_byte;
         case (beat.req_type)
            REQ_FRAME_ERR: begin
               if (framing_count != 16'hFFFF) framing_count++;
               phase = PH_HEADER;
            end
            REQ_TICK: begin
               if (idle_ticks != 16'hFFFF) idle_ticks++;
            end
            REQ_RESTART: begin
               phase          = PH_NOSYNC;
               idle_ticks     = '0;
               framing_count  = '0;
               checksum_count = '0;
            end
            default: begin
               running_check = running_check ^ b;
               case (phase)
                  PH_NOSYNC: if (idle_ticks >= pause_ticks) take_header(b);
                  PH_HEADER: take_header(b);
                  PH_CMD: begin
                     hdr_cmd  = b;
                     hdr_mode = hdr_mode | {b[5], 3'b000};
                     phase    = PH_PAYLOAD;
                  end
                  default: begin
                     if (payload_pos < declared_len) begin
                        if (payload_pos < MAX_PAYLOAD)
                           payload_store[payload_pos[IDX_W-1:0]] = b;
                        payload_pos++;
                     end else begin
                        close_message();
                     end
                  end
               endcase
               idle_ticks = '0;
            end
         endcase
      endfunction

      function void check_result(input rsp_payload_type got);
         rsp_payload_type want;
         string           bad;
         if (due_results.size() == 0) begin
            flag({"result with nothing due: ", describe(got)});
            return;
         end
         want = due_results.pop_front();
         bad  = "";
         if (got.status !== want.status)                   bad = {bad, " status"};
         if (got.msg_type !== want.msg_type)               bad = {bad, " msg_type"};
         if (got.msg_mode !== want.msg_mode)               bad = {bad, " msg_mode"};
         if (got.msg_cmd !== want.msg_cmd)                 bad = {bad, " msg_cmd"};
         if (got.payload_len !== want.payload_len)         bad = {bad, " payload_len"};
         if (got.byte_index !== want.byte_index)           bad = {bad, " byte_index"};
         if (got.payload_byte !== want.payload_byte)       bad = {bad, " payload_byte"};
         if (got.last !== want.last)                       bad = {bad, " last"};
         if (got.framing_errors !== want.framing_errors)   bad = {bad, " framing_errors"};
         if (got.checksum_errors !== want.checksum_errors) bad = {bad, " checksum_errors"};
         if (bad != "")
            flag({"mismatch in", bad, "\n   want ", describe(want), "\n   got  ", describe(got)});
      endfunction

      function void report_leftovers();
         while (due_results.size() != 0)
            flag({"result never arrived: ", describe(due_results.pop_front())});
      endfunction
   endclass

endpackage

>>> dv/device_message_deframer_tb.sv
// Bench for device_message_deframer: drives byte, tick, framing-error and restart beats, checks
// every result beat against the scoreboard in dmd_tb_pkg. Depends on dmd_pkg, dmd_tb_pkg, RTL.
module device_message_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dmd_pkg::*;
   import dmd_tb_pkg::*;

   // no beat on either side for this long means the block is hung
   localparam int STALL_LIMIT   = 2000;
   // generous settle before csr writes and at the end
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 20;
   localparam int ANY_SIZE      = -1;
   localparam logic [1:0] KIND_DATA = 2'd3;

   typedef enum int {FR_ACK, FR_SYSTEM, FR_PRG, FR_COMMAND, FR_INFO, FR_DATA, FR_ANY}
      frame_kind_type;

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready   = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_wr_en   = 1'b0;
   logic [15:0]     csr_wr_data = '0;

   message_scoreboard sb;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int send_calm     = 0;
   int recv_calm     = 0;
   int bytes_sent    = 0;
   int stall_cycles  = 0;

   device_message_deframer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Result side: check each beat taken, then pick ready for the next edge.
   // A calm stretch now and then keeps ready high for a while even in stall-heavy phases.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_payload);
      if (recv_calm > 0) begin
         recv_calm--;
         rsp_ready <= 1'b1;
      end else if ($urandom_range(0, 49) == 0) begin
         recv_calm = $urandom_range(10, 40);
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Hang detector: counts cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
         $display("device_message_deframer_tb: done, errors");
         $finish;
      end
   end

   // One input beat. Entered and left right after a rising edge; valid is only ever
   // lowered in an idle gap, so it never gets two updates in one step.
   task automatic send_beat(input logic [1:0] kind, input logic [7:0] data);
      req_payload_type beat;
      beat.req_type = kind;
      beat.rx_byte  = data;
      if (send_calm > 0) send_calm--;
      else if ($urandom_range(0, 59) == 0) send_calm = $urandom_range(10, 40);
      if (send_calm == 0) begin
         while ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.deframe_beat(beat);
      if (kind == REQ_BYTE) bytes_sent++;
   endtask

   // Hold off the sender until every due result is out. Lowers valid and waits on the clock
   // first, so a following beat never raises valid in the step that lowered it.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.due_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_pause(input logic [15:0] ticks);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ticks;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_pause(ticks);
   endtask

   // From nosync back to a state where the next byte is a header. Sometimes first
   // sends a byte too early (it must be dropped), then either waits out the pause in
   // ticks or takes the shortcut of a framing error.
   task automatic regain_sync();
      int early;
      int gap;
      gap = int'(sb.pause_ticks) - int'(sb.idle_ticks);
      if (gap > 0 && $urandom_range(0, 1) == 1) begin
         early = $urandom_range(0, (gap > 5) ? 4 : gap - 1);
         repeat (early) send_beat(REQ_TICK, 8'($urandom));
         send_beat(REQ_BYTE, 8'($urandom));
      end
      if (sb.pause_ticks <= 100 && $urandom_range(0, 1) == 1) begin
         while (sb.idle_ticks < sb.pause_ticks) send_beat(REQ_TICK, 8'($urandom));
      end else begin
         send_beat(REQ_FRAME_ERR, 8'($urandom));
      end
   endtask

   // One well-formed message with random content: header, command byte where the kind
   // takes one, 1<<f payload bytes, checksum; ACK and plain system kinds are header only.
   // Optional bad checksum; with may_cut a framing error sometimes breaks it off part way.
   task automatic send_frame(input frame_kind_type kind, input int size_code,
                             input bit bad_sum, input bit may_cut);
      logic [7:0] hdr;
      logic [7:0] sum;
      logic [7:0] data;
      logic [2:0] f;
      logic [2:0] low;
      int         roll;
      int         len;
      int         cut_at;
      int         i;
      if (kind == FR_ANY) kind = frame_kind_type'($urandom_range(FR_ACK, FR_DATA));
      if (size_code == ANY_SIZE) begin
         // mostly short; 32-byte and overlong messages now and then
         roll = $urandom_range(0, 99);
         if (roll < 80)      f = 3'($urandom_range(0, 2));
         else if (roll < 95) f = 3'($urandom_range(3, 4));
         else if (roll < 98) f = 3'd5;
         else                f = 3'($urandom_range(6, 7));
      end else begin
         f = 3'(size_code);
      end
      low = 3'($urandom_range(0, 7));

      // park the parser in the header phase first
      if (sb.phase == PH_NOSYNC && sb.idle_ticks < sb.pause_ticks) regain_sync();
      else if (sb.phase == PH_CMD || sb.phase == PH_PAYLOAD)
         send_beat(REQ_FRAME_ERR, 8'($urandom));

      case (kind)
         FR_ACK:     hdr = {KIND_SYSTEM, f, SYS_ACK};
         FR_SYSTEM: begin
            // any system code but ACK and PRG: ignored by the parser
            if (low == SYS_ACK || low == SYS_PRG) low = low ^ 3'b010;
            hdr = {KIND_SYSTEM, f, low};
         end
         FR_PRG:     hdr = {KIND_SYSTEM, f, SYS_PRG};
         FR_COMMAND: hdr = {KIND_COMMAND, f, low};
         FR_INFO:    hdr = {KIND_INFO, f, low};
         default:    hdr = {KIND_DATA, f, low};
      endcase
      send_beat(REQ_BYTE, hdr);
      if (kind == FR_ACK || kind == FR_SYSTEM) return;

      sum = hdr;
      if (kind == FR_PRG || kind == FR_INFO) begin
         data = 8'($urandom);
         send_beat(REQ_BYTE, data);
         sum = sum ^ data;
      end
      len    = 1 << f;
      cut_at = (may_cut && $urandom_range(0, 99) < 8) ? $urandom_range(0, len) : -1;
      for (i = 0; i < len; i++) begin
         if (i == cut_at) begin
            send_beat(REQ_FRAME_ERR, 8'($urandom));
            return;
         end
         // ticks inside a message only touch the idle count
         if ($urandom_range(0, 29) == 0) send_beat(REQ_TICK, 8'($urandom));
         data = 8'($urandom);
         send_beat(REQ_BYTE, data);
         sum = sum ^ data;
      end
      if (cut_at == len) begin
         send_beat(REQ_FRAME_ERR, 8'($urandom));
         return;
      end
      sum = sum ^ CHECK_GOOD;
      if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
      send_beat(REQ_BYTE, sum);
   endtask

   // Random part of a phase: mostly messages, a little raw noise (any beat kind,
   // restarts included), and now and then a full hold-off until results drain.
   task automatic run_random(input int byte_goal);
      int stop_at;
      int roll;
      stop_at = bytes_sent + byte_goal;
      while (bytes_sent < stop_at) begin
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            repeat ($urandom_range(1, 4))
               send_beat(2'($urandom_range(0, 3)), 8'($urandom));
         end else if (roll < 6) begin
            wait_drained();
         end else begin
            send_frame(FR_ANY, ANY_SIZE, $urandom_range(0, 99) < 12, 1'b1);
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // ---- phase 1: reset pause of 100; sender idles 32%, receiver stalls 57% ----
      send_idle_pct = 32;
      recv_idle_pct = 57;
      // still in nosync with no pause behind it: this ACK pattern must be dropped
      send_beat(REQ_BYTE, {KIND_SYSTEM, 3'd0, SYS_ACK});
      // a framing error puts the parser in the header phase without any pause
      send_beat(REQ_FRAME_ERR, 8'hFF);
      send_frame(FR_ACK, 0, 1'b0, 1'b0);
      send_frame(FR_SYSTEM, 7, 1'b0, 1'b0);
      send_beat(REQ_BYTE, 8'h00);
      send_frame(FR_COMMAND, 0, 1'b0, 1'b0);
      send_frame(FR_INFO, 1, 1'b0, 1'b0);
      send_frame(FR_PRG, 0, 1'b0, 1'b0);
      send_frame(FR_DATA, 0, 1'b1, 1'b0);
      send_frame(FR_INFO, 0, 1'b0, 1'b0);
      // message broken off by a framing error after one payload byte
      send_beat(REQ_BYTE, {KIND_COMMAND, 3'd2, 3'd1});
      send_beat(REQ_BYTE, 8'hFF);
      send_beat(REQ_FRAME_ERR, 8'h00);
      send_frame(FR_DATA, 1, 1'b0, 1'b0);
      // restart: the pause counts again from zero; exactly the reset pause syncs
      send_beat(REQ_RESTART, 8'h00);
      repeat (int'(SYNC_PAUSE_RESET)) send_beat(REQ_TICK, 8'($urandom));
      send_frame(FR_COMMAND, 1, 1'b0, 1'b0);
      run_random(12);

      // ---- phase 2: no pause at all; roles swapped ----
      write_pause(16'h0000);
      send_idle_pct = 57;
      recv_idle_pct = 32;
      run_random(12);

      // ---- phase 3: longest pause; size extremes, no idling ----
      write_pause(16'hFFFF);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_beat(REQ_RESTART, 8'hFF);
      // full store, then overlong with a good and with a bad checksum
      send_frame(FR_DATA, 5, 1'b0, 1'b0);
      send_frame(FR_DATA, 6, 1'b0, 1'b0);
      send_frame(FR_COMMAND, 6, 1'b1, 1'b0);
      send_beat(REQ_RESTART, 8'h00);
      send_frame(FR_ACK, 7, 1'b0, 1'b0);

      // ---- phase 4: random short pause, no idling ----
      write_pause(16'($urandom_range(1, 40)));
      run_random(12);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.report_leftovers();
      if (sb.fail_count == 0) begin
         $display("device_message_deframer_tb: done, clean");
      end else begin
         $display("device_message_deframer_tb: done, errors");
      end
      $finish;
   end

endmodule
